@@ hdl/skf_pkg.sv @@
// ============================================================================
// skf_pkg
// Shared types and constants of the scalar Kalman filter: field widths,
// register reset values, request and register codes, control structs.
// ============================================================================
package skf_pkg;

    // Widths of the data fields (Q16.16 values in 32 bits).
    localparam int DATA_W        = 32;
    localparam int REQ_W         = 2;
    localparam int CFG_IDX_W     = 2;

    // Default number of fraction bits of the gain.
    localparam int GAIN_BITS_DEF = 16;

    // Reset values of the state and of the configuration registers.
    localparam logic [DATA_W-1:0] RST_INIT_EST  = 32'd1310720;
    localparam logic [DATA_W-1:0] RST_INIT_VAR  = 32'd655360;
    localparam logic [DATA_W-1:0] RST_PROC_NOISE = 32'd6554;
    localparam logic [DATA_W-1:0] RST_MEAS_NOISE = 32'd131072;

    // Request codes carried on the input channel.
    typedef enum logic [REQ_W-1:0] {
        REQ_STEP    = 2'd0,
        REQ_PREDICT = 2'd1,
        REQ_UPDATE  = 2'd2,
        REQ_RESTART = 2'd3
    } t_req;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_INIT_EST   = 2'd0,
        CFG_INIT_VAR   = 2'd1,
        CFG_PROC_NOISE = 2'd2,
        CFG_MEAS_NOISE = 2'd3
    } t_cfg_idx;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic cap_in;
        logic do_pred;
        logic do_dset;
        logic do_div;
        logic do_mul1;
        logic do_mul2;
        logic do_fin;
        logic do_load;
        logic out_load;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic div_done;
    } t_status;

endpackage

@@ hdl/skf_in_if.sv @@
// ============================================================================
// skf_in_if
// Request channel: request type and measurement with valid/ready.
// ============================================================================
interface skf_in_if;
    import skf_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [REQ_W-1:0]         req_type;
    logic signed [DATA_W-1:0] measurement;

    modport source (output valid, output req_type, output measurement, input ready);
    modport sink   (input valid, input req_type, input measurement, output ready);
endinterface

@@ hdl/skf_out_if.sv @@
// ============================================================================
// skf_out_if
// Result channel: estimate and variance with valid/ready.
// ============================================================================
interface skf_out_if;
    import skf_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] estimate;
    logic [DATA_W-1:0]        variance;

    modport source (output valid, output estimate, output variance, input ready);
    modport sink   (input valid, input estimate, input variance, output ready);
endinterface

@@ hdl/skf_cfg_if.sv @@
// ============================================================================
// skf_cfg_if
// Configuration write channel: register index and data with valid/ready.
// ============================================================================
interface skf_cfg_if;
    import skf_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [DATA_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ hdl/skf_ctrl.sv @@
// ============================================================================
// skf_ctrl
// Sequencer of the filter: walks one request through predict, gain division,
// two multiplies, finish or restart load, and the result hand-off.
// ============================================================================
module skf_ctrl (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    input  logic [skf_pkg::REQ_W-1:0] i_in_req_type,
    output logic                     o_in_ready,
    input  logic                     i_out_ready,
    output logic                     o_out_valid,
    input  skf_pkg::t_status         i_status,
    output skf_pkg::t_cmd            o_cmd
);
    import skf_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_PRED = 9'b000000010,
        S_DSET = 9'b000000100,
        S_DIV  = 9'b000001000,
        S_MUL1 = 9'b000010000,
        S_MUL2 = 9'b000100000,
        S_FIN  = 9'b001000000,
        S_LOAD = 9'b010000000,
        S_OUT  = 9'b100000000
    } t_state;

    t_state           r_state, n_state;
    logic [REQ_W-1:0] r_req, n_req;
    logic             r_out_valid, n_out_valid;

    // The input is open only when idle and out of reset.
    assign o_in_ready  = (r_state == S_IDLE) && i_rst_n;
    assign o_out_valid = r_out_valid;

    // Next state and commands.
    always_comb begin
        n_state     = r_state;
        n_req       = r_req;
        o_cmd       = '0;
        n_out_valid = r_out_valid & ~i_out_ready;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.cap_in = 1'b1;
                    n_req        = i_in_req_type;
                    case (i_in_req_type)
                        REQ_STEP, REQ_PREDICT: n_state = S_PRED;
                        REQ_UPDATE:            n_state = S_DSET;
                        default:               n_state = S_LOAD;
                    endcase
                end
            end
            S_PRED: begin
                o_cmd.do_pred = 1'b1;
                n_state       = (r_req == REQ_STEP) ? S_DSET : S_OUT;
            end
            S_DSET: begin
                o_cmd.do_dset = 1'b1;
                n_state       = S_DIV;
            end
            S_DIV: begin
                o_cmd.do_div = 1'b1;
                if (i_status.div_done) begin
                    n_state = S_MUL1;
                end
            end
            S_MUL1: begin
                o_cmd.do_mul1 = 1'b1;
                n_state       = S_MUL2;
            end
            S_MUL2: begin
                o_cmd.do_mul2 = 1'b1;
                n_state       = S_FIN;
            end
            S_FIN: begin
                o_cmd.do_fin = 1'b1;
                n_state      = S_OUT;
            end
            S_LOAD: begin
                o_cmd.do_load = 1'b1;
                n_state       = S_OUT;
            end
            S_OUT: begin
                // Hand the result to the output register once it is free.
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_req       <= REQ_STEP;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_req       <= n_req;
            r_out_valid <= n_out_valid;
        end
    end

`ifndef SYNTHESIS
    // An accepted request keeps the input closed on the following cycle.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input reopened right after a request was taken");

    // A restart reaches the result stage without passing the division.
    a_restart_path: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.do_load |=> (r_state == S_OUT))
        else $error("restart did not go straight to the result stage");

    // A pending result is never overwritten before it is taken.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> (!r_out_valid || i_out_ready))
        else $error("result register loaded while still occupied");
`endif

endmodule

@@ hdl/skf_dp.sv @@
// ============================================================================
// skf_dp
// Datapath of the filter: configuration and state registers, restoring
// divider for the gain, one shared multiplier, rounding and saturation.
// ============================================================================
module skf_dp #(
    parameter int GAIN_BITS = skf_pkg::GAIN_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  skf_pkg::t_cmd                     i_cmd,
    output skf_pkg::t_status                  o_status,
    input  logic                              i_cfg_we,
    input  logic [skf_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [skf_pkg::DATA_W-1:0]        i_cfg_data,
    input  logic signed [skf_pkg::DATA_W-1:0] i_meas,
    output logic signed [skf_pkg::DATA_W-1:0] o_estimate,
    output logic [skf_pkg::DATA_W-1:0]        o_variance
);
    import skf_pkg::*;

    localparam int GW  = GAIN_BITS + 1;           // gain width, holds 1.0
    localparam int MW  = DATA_W + 1;              // magnitude and divisor width
    localparam int RW  = DATA_W + 2;              // partial remainder width
    localparam int PW  = MW + GW;                 // product width
    localparam int CW  = $clog2(GAIN_BITS + 1);   // division step counter
    localparam logic [GW-1:0] GAIN_ONE  = GW'(1) << GAIN_BITS;
    localparam logic [PW-1:0] GAIN_HALF = PW'(1) << (GAIN_BITS - 1);
    localparam logic signed [DATA_W+2:0] EST_MAX = {4'b0000, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W+2:0] EST_MIN = {4'b1111, {(DATA_W-1){1'b0}}};

    // Configuration and filter state.
    logic [DATA_W-1:0]        r_init_est, r_init_var, r_proc_noise, r_meas_noise;
    logic signed [DATA_W-1:0] r_est;
    logic [DATA_W-1:0]        r_var;

    // Working registers of one request.
    logic signed [DATA_W-1:0] r_meas;
    logic [MW-1:0]            r_den;
    logic [RW-1:0]            r_rem;
    logic [GW-1:0]            r_quot;
    logic [CW-1:0]            r_cnt;
    logic                     r_neg;
    logic [MW-1:0]            r_mag;
    logic [PW-1:0]            r_prod;
    logic signed [DATA_W-1:0] r_out_est;
    logic [DATA_W-1:0]        r_out_var;

    logic [DATA_W:0]          pred_sum;
    logic signed [DATA_W:0]   diff;
    logic                     den_zero;
    logic [GW-1:0]            gain;
    logic                     rem_ge;
    logic [RW-1:0]            rem_sub;
    logic [MW-1:0]            mul_a;
    logic [GW-1:0]            mul_b;
    logic [PW-1:0]            prod_rnd;
    logic [MW-1:0]            mag_rnd;
    logic signed [DATA_W+2:0] corr;
    logic signed [DATA_W+2:0] est_next;
    logic signed [DATA_W-1:0] est_sat;

    assign o_estimate = r_out_est;
    assign o_variance = r_out_var;

    // Predict: variance plus process noise, saturated.
    assign pred_sum = {1'b0, r_var} + {1'b0, r_proc_noise};

    // Innovation and its magnitude.
    assign diff = {r_meas[DATA_W-1], r_meas} - {r_est[DATA_W-1], r_est};

    // Gain is zero when the denominator is zero.
    assign den_zero = (r_den == '0);
    assign gain     = den_zero ? '0 : r_quot;

    // One restoring division step.
    assign rem_ge  = (r_rem >= {1'b0, r_den});
    assign rem_sub = rem_ge ? (r_rem - {1'b0, r_den}) : r_rem;
    assign o_status.div_done = (r_cnt == CW'(GAIN_BITS));

    // Shared multiplier: correction first, then the variance scale.
    assign mul_a = i_cmd.do_mul2 ? {1'b0, r_var} : r_mag;
    assign mul_b = i_cmd.do_mul2 ? (GAIN_ONE - gain) : gain;

    // Round half away from zero on the magnitude, drop the gain fraction.
    assign prod_rnd = r_prod + GAIN_HALF;
    assign mag_rnd  = prod_rnd[GAIN_BITS +: MW];

    // New estimate, saturated to the signed range.
    assign corr     = r_neg ? -$signed({2'b00, mag_rnd}) : $signed({2'b00, mag_rnd});
    assign est_next = {{3{r_est[DATA_W-1]}}, r_est} + corr;
    always_comb begin
        if (est_next > EST_MAX) begin
            est_sat = EST_MAX[DATA_W-1:0];
        end else if (est_next < EST_MIN) begin
            est_sat = EST_MIN[DATA_W-1:0];
        end else begin
            est_sat = est_next[DATA_W-1:0];
        end
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init_est   <= RST_INIT_EST;
            r_init_var   <= RST_INIT_VAR;
            r_proc_noise <= RST_PROC_NOISE;
            r_meas_noise <= RST_MEAS_NOISE;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_INIT_EST:   r_init_est   <= i_cfg_data;
                CFG_INIT_VAR:   r_init_var   <= i_cfg_data;
                CFG_PROC_NOISE: r_proc_noise <= i_cfg_data;
                CFG_MEAS_NOISE: r_meas_noise <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Estimate and variance.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_est <= RST_INIT_EST;
            r_var <= RST_INIT_VAR;
        end else begin
            if (i_cmd.do_pred) begin
                r_var <= pred_sum[DATA_W] ? '1 : pred_sum[DATA_W-1:0];
            end
            if (i_cmd.do_mul2) begin
                r_est <= est_sat;
            end
            if (i_cmd.do_fin) begin
                r_var <= mag_rnd[DATA_W-1:0];
            end
            if (i_cmd.do_load) begin
                r_est <= r_init_est;
                r_var <= r_init_var;
            end
        end
    end

    // Working registers of the update.
    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_in) begin
            r_meas <= i_meas;
        end
        if (i_cmd.do_dset) begin
            r_den  <= {1'b0, r_var} + {1'b0, r_meas_noise};
            r_rem  <= {2'b00, r_var};
            r_quot <= '0;
            r_cnt  <= '0;
            r_neg  <= diff[DATA_W];
            r_mag  <= diff[DATA_W] ? MW'(-diff) : MW'(diff);
        end
        if (i_cmd.do_div) begin
            r_rem  <= {rem_sub[RW-2:0], 1'b0};
            r_quot <= {r_quot[GW-2:0], rem_ge};
            r_cnt  <= r_cnt + CW'(1);
        end
        if (i_cmd.do_mul1 || i_cmd.do_mul2) begin
            r_prod <= PW'(mul_a) * PW'(mul_b);
        end
        if (i_cmd.out_load) begin
            r_out_est <= r_est;
            r_out_var <= r_var;
        end
    end

`ifndef SYNTHESIS
    // The gain never exceeds 1.0 since the variance is part of the divisor.
    a_gain_le_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.do_mul1 |-> (gain <= GAIN_ONE))
        else $error("gain above one");

    // The rounded correction never exceeds the innovation magnitude.
    a_corr_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.do_mul2 |-> (mag_rnd <= r_mag))
        else $error("correction larger than innovation");

    // An update never raises the variance.
    a_var_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.do_fin |=> (r_var <= $past(r_var)))
        else $error("variance grew in update");
`endif

endmodule

@@ hdl/scalar_kalman_filter.sv @@
// ============================================================================
// scalar_kalman_filter
// Scalar constant-model Kalman filter in Q16.16 fixed point.
// ============================================================================
// Usage: i_in takes one request per beat (req_type, measurement); o_out
// returns one beat per request carrying the estimate and variance after it.
// Request 0 runs predict then update, 1 predict only, 2 update only, and 3
// reloads estimate and variance from the configuration registers. i_cfg
// writes those registers (index 0..3) and is ready whenever reset is
// released; write only while no request is in flight.
// Timing: one request at a time. A full step runs predict and update,
// update only skips the predict, and predict only and restart skip the
// division and the multiplies. The gain division is a restoring divider
// that retires one quotient bit per cycle, GAIN_BITS+1 steps; both
// products share one multiplier. A new request is taken only once the
// sequencer is back in idle after the result is registered.
// Reset clears the filter to 20.0 estimate and 10.0 variance and restores
// the register defaults. When the receiver stalls, the result waits in the
// output register; the next request is still taken and worked on, and holds
// only at its own result stage until the pending beat leaves.
// ============================================================================
module scalar_kalman_filter #(
    parameter int GAIN_BITS = skf_pkg::GAIN_BITS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    skf_in_if.sink    i_in,
    skf_out_if.source o_out,
    skf_cfg_if.sink   i_cfg
);
    import skf_pkg::*;

    t_cmd    cmd;
    t_status status;

    // Configuration writes are taken on every cycle out of reset.
    assign i_cfg.ready = i_rst_n;

    // Sequencer.
    skf_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in.valid),
        .i_in_req_type (i_in.req_type),
        .o_in_ready    (i_in.ready),
        .i_out_ready   (o_out.ready),
        .o_out_valid   (o_out.valid),
        .i_status      (status),
        .o_cmd         (cmd)
    );

    // Arithmetic and state.
    skf_dp #(
        .GAIN_BITS (GAIN_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_cfg_we    (i_cfg.valid),
        .i_cfg_index (i_cfg.index),
        .i_cfg_data  (i_cfg.data),
        .i_meas      (i_in.measurement),
        .o_estimate  (o_out.estimate),
        .o_variance  (o_out.variance)
    );

endmodule
